[hw/rtl/sid_pkg.sv]
`timescale 1ns / 1ps

package sid_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int ID_W             = 8;
    localparam int FUNC_W           = 2;
    localparam int COUNT_W          = 7;

    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_PUT,
        ST_RESP
    } state_t;

endpackage

[hw/rtl/sorted_id_set.sv]
`timescale 1ns / 1ps
// Lookup scans the entries in order until it meets the key or a larger one; insert of a new
//   key also shifts the entries above its slot up by one and then writes it; insert of a held
//   key acts as a lookup; clear, insert into a full table and unused codes go straight to the result.
// One operation at a time: no new input transfer is taken until the result has been handed
//   to the output register, as the entry memory has single ports and there is one compare unit.
// Reset (aresetn low, synchronous): empty the set, drop any result, idle; memory not cleared.
module sorted_id_set #(
    parameter int CAPACITY = sid_pkg::DEFAULT_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] id
    input  logic [1:0]  s_tuser,   // [1:0] func
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] ok, [7:1] entry_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    sid_pkg::state_t state_reg, state_next;

    logic [CW-1:0]              fill_reg, fill_next;
    logic [CW-1:0]              idx_reg,  idx_next;
    logic [CW-1:0]              pos_reg,  pos_next;
    logic [sid_pkg::FUNC_W-1:0] op_reg,   op_next;
    logic [sid_pkg::ID_W-1:0]   key_reg,  key_next;
    logic                       ok_reg,   ok_next;

    logic                       m_valid_reg, m_valid_next;
    logic                       m_ok_reg,    m_ok_next;
    logic [sid_pkg::COUNT_W-1:0] m_count_reg, m_count_next;

    // entry memory: one write and one registered read port
    logic [sid_pkg::ID_W-1:0] mem [CAPACITY];
    logic [sid_pkg::ID_W-1:0] rd_data_reg;
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [sid_pkg::ID_W-1:0] mem_wdata;
    logic [AW-1:0]            mem_raddr;

    logic s_xfer;
    logic resp_free;

    assign s_tready  = (state_reg == sid_pkg::ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign resp_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_count_reg, m_ok_reg};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sid_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    if (s_tuser == sid_pkg::FUNC_LOOKUP) begin
                        state_next = sid_pkg::ST_SCAN_RD;
                    end else if (s_tuser == sid_pkg::FUNC_INSERT && fill_reg < CAP_C) begin
                        state_next = sid_pkg::ST_SCAN_RD;
                    end else begin
                        state_next = sid_pkg::ST_RESP;
                    end
                end
            end
            sid_pkg::ST_SCAN_RD: begin
                if (idx_reg == fill_reg) begin
                    state_next = (op_reg == sid_pkg::FUNC_INSERT) ? sid_pkg::ST_PUT
                                                                  : sid_pkg::ST_RESP;
                end else begin
                    state_next = sid_pkg::ST_SCAN_CMP;
                end
            end
            sid_pkg::ST_SCAN_CMP: begin
                if (rd_data_reg == key_reg) begin
                    state_next = sid_pkg::ST_RESP;
                end else if (rd_data_reg > key_reg) begin
                    state_next = (op_reg == sid_pkg::FUNC_INSERT) ? sid_pkg::ST_SHIFT_RD
                                                                  : sid_pkg::ST_RESP;
                end else begin
                    state_next = sid_pkg::ST_SCAN_RD;
                end
            end
            sid_pkg::ST_SHIFT_RD: begin
                state_next = (idx_reg == pos_reg) ? sid_pkg::ST_PUT : sid_pkg::ST_SHIFT_WR;
            end
            sid_pkg::ST_SHIFT_WR: state_next = sid_pkg::ST_SHIFT_RD;
            sid_pkg::ST_PUT:      state_next = sid_pkg::ST_RESP;
            sid_pkg::ST_RESP: begin
                if (resp_free) begin
                    state_next = sid_pkg::ST_IDLE;
                end
            end
            default: state_next = sid_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        fill_next    = fill_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        ok_next      = ok_reg;
        m_ok_next    = m_ok_reg;
        m_count_next = m_count_reg;
        m_valid_next = m_valid_reg && !m_tready;
        mem_we       = 1'b0;
        mem_waddr    = idx_reg[AW-1:0];
        mem_wdata    = rd_data_reg;
        mem_raddr    = idx_reg[AW-1:0];

        unique case (state_reg)
            sid_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    op_next  = s_tuser;
                    key_next = s_tdata;
                    idx_next = '0;
                    ok_next  = 1'b0;
                    if (s_tuser == sid_pkg::FUNC_CLEAR) begin
                        fill_next = '0;
                        ok_next   = 1'b1;
                    end
                end
            end
            sid_pkg::ST_SCAN_RD: begin
                // record the scan position; at the end of the held entries the key goes at the top
                pos_next = idx_reg;
            end
            sid_pkg::ST_SCAN_CMP: begin
                if (rd_data_reg == key_reg) begin
                    ok_next = 1'b1;
                end else if (rd_data_reg > key_reg) begin
                    pos_next = idx_reg;
                    idx_next = fill_reg;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            sid_pkg::ST_SHIFT_RD: begin
                // fetch the entry just below the slot being filled
                mem_raddr = AW'(idx_reg - 1'b1);
            end
            sid_pkg::ST_SHIFT_WR: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[AW-1:0];
                mem_wdata = rd_data_reg;
                idx_next  = idx_reg - 1'b1;
            end
            sid_pkg::ST_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg[AW-1:0];
                mem_wdata = key_reg;
                fill_next = fill_reg + 1'b1;
                ok_next   = 1'b1;
            end
            sid_pkg::ST_RESP: begin
                if (resp_free) begin
                    m_valid_next = 1'b1;
                    m_ok_next    = ok_reg;
                    m_count_next = sid_pkg::COUNT_W'(fill_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sid_pkg::ST_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        op_reg      <= op_next;
        key_reg     <= key_next;
        ok_reg      <= ok_next;
        m_ok_reg    <= m_ok_next;
        m_count_reg <= m_count_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

endmodule

[tb/sorted_id_set_tb.sv]
`timescale 1ns / 1ps

module sorted_id_set_tb;

    localparam int                         CAPACITY    = sid_pkg::DEFAULT_CAPACITY;
    // The one operation code the block leaves unused: it changes nothing and fails.
    localparam logic [sid_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int                         RANDOM_OPS  = 360;
    // Extra wait for stray results after the last reply, with slack on top.
    localparam int                         DRAIN_CYCLES = 4 * CAPACITY + 16;

    typedef struct packed {
        logic [sid_pkg::FUNC_W-1:0] func;
        logic [sid_pkg::ID_W-1:0]   id;
    } set_op_t;

    typedef struct packed {
        logic                        ok;
        logic [sid_pkg::COUNT_W-1:0] count;
    } set_reply_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = '0;   // [7:0] id
    logic [1:0]          s_tuser  = '0;   // [1:0] func
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [7:0]          m_tdata;         // [0] ok, [7:1] entry_count

    // Operations waiting to be driven, and replies waiting to come back.
    set_op_t             pending_ops[$];
    set_reply_t          awaited_replies[$];
    int                  total_ops  = 0;
    int                  ops_sent   = 0;
    int                  mismatches = 0;

    // Shadow copy of the sorted identifier table.
    logic [sid_pkg::ID_W-1:0] shadow_ids[CAPACITY];
    int                       shadow_fill = 0;

    // Idle pattern: sender 22% / receiver 51% for the first third of the
    // transfers, swapped for the second third, no idling for the rest.
    int                  phase;
    int                  send_idle_pct;
    int                  recv_idle_pct;

    assign phase = (ops_sent * 3 < total_ops)     ? 0 :
                   (ops_sent * 3 < 2 * total_ops) ? 1 : 2;
    assign send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 51 : 0;
    assign recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 22 : 0;

    always #10 aclk = ~aclk;

    sorted_id_set #(
        .CAPACITY (CAPACITY)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Apply one operation to the shadow table and return the reply it must give.
    function automatic set_reply_t apply_set_op(set_op_t op);
        set_reply_t reply;
        logic       held;
        int         slot;
        held = 1'b0;
        for (int k = 0; k < shadow_fill; k++) begin
            if (shadow_ids[k] == op.id) held = 1'b1;
        end
        reply.ok = 1'b0;
        case (op.func)
            sid_pkg::FUNC_LOOKUP: begin
                reply.ok = held;
            end
            sid_pkg::FUNC_INSERT: begin
                // The room check wins over the duplicate check.
                if (shadow_fill >= CAPACITY) begin
                    reply.ok = 1'b0;
                end else if (held) begin
                    reply.ok = 1'b1;
                end else begin
                    slot = shadow_fill;
                    for (int k = shadow_fill - 1; k >= 0; k--) begin
                        if (shadow_ids[k] > op.id) slot = k;
                    end
                    for (int k = shadow_fill; k > slot; k--) begin
                        shadow_ids[k] = shadow_ids[k-1];
                    end
                    shadow_ids[slot] = op.id;
                    shadow_fill++;
                    reply.ok = 1'b1;
                end
            end
            sid_pkg::FUNC_CLEAR: begin
                shadow_fill = 0;
                reply.ok    = 1'b1;
            end
            default: begin
                reply.ok = 1'b0;
            end
        endcase
        reply.count = shadow_fill[sid_pkg::COUNT_W-1:0];
        return reply;
    endfunction

    task automatic queue_op(input logic [sid_pkg::FUNC_W-1:0] func,
                            input logic [sid_pkg::ID_W-1:0] id);
        set_op_t op;
        op.func = func;
        op.id   = id;
        pending_ops.push_back(op);
    endtask

    task automatic report_mismatch(input string what, input set_reply_t want,
                                   input set_reply_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t ns: %s: ok exp %0d got %0d, entry_count exp %0d got %0d",
                     $time, what, want.ok, got.ok, want.count, got.count);
        end
    endtask

    // Driver: hold the current transfer until accepted, then advance or idle.
    always @(posedge aclk) begin : drive_ops
        logic    slot_busy;
        set_op_t op;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            slot_busy = s_tvalid;
            if (s_tvalid && s_tready) begin
                op.func = s_tuser;
                op.id   = s_tdata;
                awaited_replies.push_back(apply_set_op(op));
                ops_sent <= ops_sent + 1;
                slot_busy = 1'b0;
            end
            if (!slot_busy) begin
                if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    op = pending_ops.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= op.func;
                    s_tdata  <= op.id;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transfer with the oldest awaited reply.
    always @(posedge aclk) begin : check_replies
        set_reply_t want;
        set_reply_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.ok    = m_tdata[0];
                got.count = m_tdata[7:1];
                if (awaited_replies.size() == 0) begin
                    want = '0;
                    report_mismatch("result with nothing awaited", want, got);
                end else begin
                    want = awaited_replies.pop_front();
                    if (got.ok !== want.ok || got.count !== want.count) begin
                        report_mismatch("result mismatch", want, got);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin : stimulus
        int ids[256];
        int swap;
        int pick;
        int span;
        int base;
        int roll;
        int done_directed;

        // Directed: empty lookup, id extremes, duplicate insert, middle and
        // front inserts that shift entries, hits and misses, the unused code,
        // and clears on a loaded and on an empty table.
        queue_op(sid_pkg::FUNC_LOOKUP, 8'h00);
        queue_op(sid_pkg::FUNC_INSERT, 8'h80);
        queue_op(sid_pkg::FUNC_INSERT, 8'h00);
        queue_op(sid_pkg::FUNC_INSERT, 8'hFF);
        queue_op(sid_pkg::FUNC_INSERT, 8'h80);
        queue_op(sid_pkg::FUNC_INSERT, 8'h7F);
        queue_op(sid_pkg::FUNC_LOOKUP, 8'h00);
        queue_op(sid_pkg::FUNC_LOOKUP, 8'hFF);
        queue_op(sid_pkg::FUNC_LOOKUP, 8'h7F);
        queue_op(sid_pkg::FUNC_LOOKUP, 8'h81);
        queue_op(sid_pkg::FUNC_LOOKUP, 8'h01);
        queue_op(FUNC_UNUSED, 8'hAA);
        queue_op(FUNC_UNUSED, 8'h55);
        queue_op(sid_pkg::FUNC_INSERT, 8'h01);
        queue_op(sid_pkg::FUNC_LOOKUP, 8'h01);
        queue_op(sid_pkg::FUNC_CLEAR,  8'hFF);
        queue_op(sid_pkg::FUNC_CLEAR,  8'h00);
        queue_op(sid_pkg::FUNC_LOOKUP, 8'hFF);
        queue_op(sid_pkg::FUNC_INSERT, 8'hAA);
        queue_op(sid_pkg::FUNC_INSERT, 8'h55);
        queue_op(sid_pkg::FUNC_LOOKUP, 8'h55);
        done_directed = pending_ops.size();

        // Random: mostly mixed bursts around a narrow id window, some well-formed fill runs that
        // reach a full table, short random runs after a clear, and some noise.
        while (pending_ops.size() < done_directed + RANDOM_OPS) begin
            roll = $urandom_range(9);
            if (roll <= 1) begin
                // Fill to capacity with distinct ids in random order, then
                // push past full with a held and a fresh id.
                for (int i = 0; i < 256; i++) ids[i] = i;
                for (int i = 255; i > 0; i--) begin
                    pick      = $urandom_range(i);
                    swap      = ids[i];
                    ids[i]    = ids[pick];
                    ids[pick] = swap;
                end
                queue_op(sid_pkg::FUNC_CLEAR, sid_pkg::ID_W'($urandom_range(255)));
                for (int i = 0; i < CAPACITY; i++) begin
                    queue_op(sid_pkg::FUNC_INSERT, sid_pkg::ID_W'(ids[i]));
                    if ($urandom_range(7) == 0) begin
                        queue_op(sid_pkg::FUNC_LOOKUP,
                                 sid_pkg::ID_W'(ids[$urandom_range(CAPACITY)]));
                    end
                end
                queue_op(sid_pkg::FUNC_INSERT,
                         sid_pkg::ID_W'(ids[$urandom_range(CAPACITY - 1)]));
                queue_op(sid_pkg::FUNC_INSERT, sid_pkg::ID_W'(ids[CAPACITY]));
                queue_op(sid_pkg::FUNC_LOOKUP, sid_pkg::ID_W'(ids[CAPACITY]));
                queue_op(sid_pkg::FUNC_LOOKUP,
                         sid_pkg::ID_W'(ids[$urandom_range(CAPACITY - 1)]));
            end else if (roll <= 6) begin
                // Mixed burst; a narrow window makes hits and duplicates common.
                span = $urandom_range(60, 20);
                base = $urandom_range(255);
                for (int i = 0; i < span; i++) begin
                    pick = ($urandom_range(1) == 0) ? (base + $urandom_range(15)) % 256
                                                    : $urandom_range(255);
                    if ($urandom_range(99) < 55) begin
                        queue_op(sid_pkg::FUNC_INSERT, sid_pkg::ID_W'(pick));
                    end else begin
                        queue_op(sid_pkg::FUNC_LOOKUP, sid_pkg::ID_W'(pick));
                    end
                end
            end else if (roll == 7) begin
                queue_op(sid_pkg::FUNC_CLEAR, sid_pkg::ID_W'($urandom_range(255)));
                for (int i = 0; i < 8; i++) begin
                    queue_op(($urandom_range(1) == 0) ? sid_pkg::FUNC_INSERT
                                                      : sid_pkg::FUNC_LOOKUP,
                             sid_pkg::ID_W'($urandom_range(255)));
                end
            end else begin
                // Noise: unused code and stray clears between lookups.
                for (int i = 0; i < 4; i++) begin
                    case ($urandom_range(2))
                        0:       queue_op(FUNC_UNUSED, sid_pkg::ID_W'($urandom_range(255)));
                        1:       queue_op(sid_pkg::FUNC_LOOKUP,
                                          sid_pkg::ID_W'($urandom_range(255)));
                        default: queue_op(($urandom_range(3) == 0) ? sid_pkg::FUNC_CLEAR
                                                                    : FUNC_UNUSED,
                                          sid_pkg::ID_W'($urandom_range(255)));
                    endcase
                end
            end
        end
        total_ops = pending_ops.size();

        // Hold reset at the start, then release it once for the whole run.
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for every transfer to go out and every reply to come back,
        // then watch a little longer for stray results.
        while (ops_sent < total_ops || awaited_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && awaited_replies.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #(20_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
